>>> rtl/core/pwm_prescaler_and_period_calc_assert.svh
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator: assertion macros
// Concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef PWM_PRESCALER_AND_PERIOD_CALC_ASSERT_SVH
`define PWM_PRESCALER_AND_PERIOD_CALC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ppc_pkg.sv
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator: package
// Field widths, prescaler tables and shared types of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int FREQ_W   = 28;
    localparam int DUTY_W   = 17;
    localparam int COUNT_W  = 16;
    localparam int RATIO_W  = 11;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int TAB_IDX_W = 3;
    localparam int LOG2_W   = 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_LOG2  = 1'b1;

    localparam logic [CFG_W-1:0] MASTER_LOG2_RST = 5'd23;
    localparam logic [CFG_W-1:0] COUNT_LOG2_RST  = 5'd16;

    // Divider: numerator is 2^(M+5-k) + f, denominator is 2f.
    localparam int NUM_W      = 37;
    localparam int DEN_W      = FREQ_W + 1;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Multiplier: period times duty fraction.
    localparam int PROD_W     = COUNT_W + DUTY_W;
    localparam int MUL_STEPS  = DUTY_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 16'd2;

    typedef struct packed {
        logic               ovf;
        logic [COUNT_W-1:0] quot;
    } t_div_res;

    function automatic logic [LOG2_W-1:0] ratio_log2(input logic [TAB_IDX_W-1:0] idx);
        logic [LOG2_W-1:0] v;
        unique case (idx)
            3'd0:    v = 4'd0;
            3'd1:    v = 4'd3;
            3'd2:    v = 4'd6;
            3'd3:    v = 4'd8;
            default: v = 4'd10;
        endcase
        return v;
    endfunction

    function automatic logic [RATIO_W-1:0] ratio_value(input logic [TAB_IDX_W-1:0] idx);
        logic [RATIO_W-1:0] v;
        unique case (idx)
            3'd0:    v = 11'd1;
            3'd1:    v = 11'd8;
            3'd2:    v = 11'd64;
            3'd3:    v = 11'd256;
            default: v = 11'd1024;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/ppc_div.sv
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator: serial divider
// Restoring divider, one quotient bit per cycle, low 16 quotient bits kept
// and any higher set bit reported as overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppc_pkg::NUM_W-1:0]     i_num,
    input  logic [ppc_pkg::DEN_W-1:0]     i_den,
    output logic                          o_done,
    output ppc_pkg::t_div_res             o_res
);

    logic                            r_busy;
    logic                            r_done;
    logic [ppc_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ppc_pkg::NUM_W-1:0]       r_num;
    logic [ppc_pkg::DEN_W-1:0]       r_den;
    logic [ppc_pkg::DEN_W-1:0]       r_rem;
    logic [ppc_pkg::COUNT_W-1:0]     r_quot;
    logic                            r_ovf;

    logic [ppc_pkg::DEN_W:0]         w_trial;
    logic [ppc_pkg::DEN_W+1:0]       w_sub;
    logic                            w_ge;
    logic                            w_last;

    // Bring down the next numerator bit and try to subtract the divisor.
    assign w_trial = {r_rem, r_num[ppc_pkg::NUM_W-1]};
    assign w_sub   = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge    = ~w_sub[ppc_pkg::DEN_W+1];
    assign w_last  = (r_cnt == ppc_pkg::DIV_CNT_W'(ppc_pkg::DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[ppc_pkg::NUM_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_sub[ppc_pkg::DEN_W-1:0] : w_trial[ppc_pkg::DEN_W-1:0];
            r_quot <= {r_quot[ppc_pkg::COUNT_W-2:0], w_ge};
            r_ovf  <= r_ovf | r_quot[ppc_pkg::COUNT_W-1];
        end
    end

    assign o_done     = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_quot;

endmodule

>>> rtl/core/ppc_mul.sv
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator: serial multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppc_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ppc_pkg::COUNT_W-1:0]   i_a,
    input  logic [ppc_pkg::DUTY_W-1:0]    i_b,
    output logic                          o_done,
    output logic [ppc_pkg::PROD_W-1:0]    o_prod
);

    logic                            r_busy;
    logic                            r_done;
    logic [ppc_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic [ppc_pkg::COUNT_W-1:0]     r_a;
    logic [ppc_pkg::DUTY_W-1:0]      r_b;
    logic [ppc_pkg::PROD_W-1:0]      r_acc;

    logic [ppc_pkg::PROD_W-1:0]      w_addend;
    logic                            w_last;

    assign w_addend = r_b[ppc_pkg::DUTY_W-1] ? ppc_pkg::PROD_W'(r_a) : '0;
    assign w_last   = (r_cnt == ppc_pkg::MUL_CNT_W'(ppc_pkg::MUL_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= {r_b[ppc_pkg::DUTY_W-2:0], 1'b0};
            r_acc <= {r_acc[ppc_pkg::PROD_W-2:0], 1'b0} + w_addend;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> rtl/core/pwm_prescaler_and_period_calc.sv
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator
// Picks a timer prescaler and computes the top count and compare count for a
// requested PWM frequency and duty fraction.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries a frequency in 1/16 Hz and a Q1.16 duty fraction;
// a transfer happens on a rising edge with i_in_valid high and o_in_stall low.
// Each input transfer yields exactly one result on the output channel, which
// transfers on an edge with o_out_valid high and i_out_stall low.
// An input transfer passes through the prescaler search, the bit-serial
// divider, the bit-serial multiplier and the handoff into the output
// register before o_out_valid rises.
// The serial divider sets the pace; one item is worked on at a time, and a
// new item can be taken in the cycle after its predecessor's result has
// been written into the output register.
// A finished result sits in the output register while the next item is
// taken and processed. If the receiver keeps stalling, the core holds its
// finished result until the output register frees up, then the input side
// stalls. The configuration port writes master_clock_log2 (index 0) and
// count_width_log2 (index 1) and must only be used while the block is idle.
// Reset is synchronous: the pipeline empties and the registers return to
// 23 and 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwm_prescaler_and_period_calc #(
    parameter int NUM_PRESCALERS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppc_pkg::CFG_W-1:0]       i_cfg_wdata,
    // Input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ppc_pkg::FREQ_W-1:0]      i_frequency_q4,
    input  logic [ppc_pkg::DUTY_W-1:0]      i_duty_fraction,
    // Output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ppc_pkg::COUNT_W-1:0]     o_period_count,
    output logic [ppc_pkg::COUNT_W-1:0]     o_duty_count,
    output logic [ppc_pkg::RATIO_W-1:0]     o_divide_ratio,
    output logic                            o_clamped_high,
    output logic                            o_clamped_low
);

    `include "pwm_prescaler_and_period_calc_assert.svh"

    localparam int IDX_W = (NUM_PRESCALERS > 1) ? $clog2(NUM_PRESCALERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PRESCALERS - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PICK = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [IDX_W-1:0]                r_idx;
    logic [IDX_W-1:0]                n_idx;

    logic [ppc_pkg::CFG_W-1:0]       r_master_log2;
    logic [ppc_pkg::CFG_W-1:0]       r_count_log2;

    logic [ppc_pkg::FREQ_W-1:0]      r_freq;
    logic [ppc_pkg::DUTY_W-1:0]      r_duty_frac;
    logic [ppc_pkg::COUNT_W-1:0]     r_period;
    logic                            r_hi;
    logic                            r_lo;
    logic [ppc_pkg::COUNT_W-1:0]     r_duty;

    logic                            r_out_valid;
    logic [ppc_pkg::COUNT_W-1:0]     r_out_period;
    logic [ppc_pkg::COUNT_W-1:0]     r_out_duty;
    logic [ppc_pkg::RATIO_W-1:0]     r_out_ratio;
    logic                            r_out_hi;
    logic                            r_out_lo;

    logic                            w_in_xfer;
    logic                            w_out_load;
    logic [ppc_pkg::LOG2_W-1:0]      w_k;
    logic signed [6:0]               w_pick_exp;
    logic signed [6:0]               w_num_exp;
    logic [ppc_pkg::DEN_W-1:0]       w_thr;
    logic                            w_go;
    logic [ppc_pkg::NUM_W-1:0]       w_pow;
    logic [ppc_pkg::NUM_W-1:0]       w_num;
    logic                            w_div_start;
    logic                            w_div_done;
    ppc_pkg::t_div_res               w_div_res;
    logic [ppc_pkg::COUNT_W-1:0]     w_period;
    logic                            w_hi;
    logic                            w_lo;
    logic                            w_mul_start;
    logic                            w_mul_done;
    logic [ppc_pkg::PROD_W-1:0]      w_prod;
    logic [ppc_pkg::PROD_W:0]        w_round;
    logic [ppc_pkg::PROD_W-ppc_pkg::COUNT_W:0] w_duty_wide;
    logic [ppc_pkg::COUNT_W-1:0]     w_duty_sat;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Prescaler test for the current index: the prescaler 2^k is too small
    // while f <= 2^(M - W + 4 - k). A negative exponent can only pass for a
    // zero frequency, and an exponent of 28 or more passes any frequency.
    assign w_k        = ppc_pkg::ratio_log2(ppc_pkg::TAB_IDX_W'(r_idx));
    assign w_pick_exp = $signed({2'b00, r_master_log2}) - $signed({2'b00, r_count_log2})
                        + 7'sd4 - $signed({3'b000, w_k});
    assign w_thr      = ppc_pkg::DEN_W'(1) << w_pick_exp[4:0];
    assign w_go       = (r_freq == '0)
                        || (!w_pick_exp[6]
                            && ((w_pick_exp >= 7'sd28) || ({1'b0, r_freq} <= w_thr)));

    // round(2^(M+4-k) / f) is floor((2^(M+5-k) + f) / 2f). When M+5-k is
    // negative the quotient is zero, so the power term is simply dropped.
    // A zero frequency makes the divider return all ones, which lands on the
    // high clamp as required.
    assign w_num_exp = $signed({2'b00, r_master_log2}) + 7'sd5 - $signed({3'b000, w_k});
    assign w_pow     = w_num_exp[6] ? '0 : (ppc_pkg::NUM_W'(1) << w_num_exp[5:0]);
    assign w_num     = w_pow + ppc_pkg::NUM_W'(r_freq);

    // The period clamp is decided on the divider result. The clamped value
    // goes straight to the multiplier in the cycle it starts, and is also
    // kept for the output.
    always_comb begin
        priority if (w_div_res.ovf) begin
            w_period = ppc_pkg::COUNT_MAX;
            w_hi     = 1'b1;
            w_lo     = 1'b0;
        end else if (w_div_res.quot < ppc_pkg::COUNT_MIN) begin
            w_period = ppc_pkg::COUNT_MIN;
            w_hi     = 1'b0;
            w_lo     = 1'b1;
        end else begin
            w_period = w_div_res.quot;
            w_hi     = 1'b0;
            w_lo     = 1'b0;
        end
    end

    // Duty rounding: (period * duty + 2^15) >> 16, saturated to 1..65535.
    assign w_round     = {1'b0, w_prod} + (ppc_pkg::PROD_W + 1)'(32768);
    assign w_duty_wide = w_round[ppc_pkg::PROD_W:ppc_pkg::COUNT_W];

    always_comb begin
        priority if (w_duty_wide[ppc_pkg::PROD_W-ppc_pkg::COUNT_W:ppc_pkg::COUNT_W] != '0) begin
            w_duty_sat = ppc_pkg::COUNT_MAX;
        end else if (w_duty_wide[ppc_pkg::COUNT_W-1:0] == '0) begin
            w_duty_sat = ppc_pkg::COUNT_W'(1);
        end else begin
            w_duty_sat = w_duty_wide[ppc_pkg::COUNT_W-1:0];
        end
    end

    // Sequencer: search the prescaler, divide, multiply, hand off.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        w_div_start = 1'b0;
        w_mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_PICK;
                    n_idx   = '0;
                end
            end
            S_PICK: begin
                if (w_go && (r_idx != LAST_IDX)) begin
                    n_idx = r_idx + 1'b1;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_mul_start = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
            r_master_log2 <= ppc_pkg::MASTER_LOG2_RST;
            r_count_log2  <= ppc_pkg::COUNT_LOG2_RST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    ppc_pkg::REG_MASTER_LOG2: r_master_log2 <= i_cfg_wdata;
                    ppc_pkg::REG_COUNT_LOG2:  r_count_log2  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_freq      <= i_frequency_q4;
            r_duty_frac <= i_duty_fraction;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_period <= w_period;
            r_hi     <= w_hi;
            r_lo     <= w_lo;
        end
        if ((r_state == S_MUL) && w_mul_done) begin
            r_duty <= w_duty_sat;
        end
        if (w_out_load) begin
            r_out_period <= r_period;
            r_out_duty   <= r_duty;
            r_out_ratio  <= ppc_pkg::ratio_value(ppc_pkg::TAB_IDX_W'(r_idx));
            r_out_hi     <= r_hi;
            r_out_lo     <= r_lo;
        end
    end

    ppc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   ({r_freq, 1'b0}),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    ppc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_period),
        .i_b     (r_duty_frac),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_period_count = r_out_period;
    assign o_duty_count   = r_out_duty;
    assign o_divide_ratio = r_out_ratio;
    assign o_clamped_high = r_out_hi;
    assign o_clamped_low  = r_out_lo;

    // A result never carries both clamp flags, and its period is at least two.
    `PPC_ASSERT_IMPLY(a_clamp_excl, i_clk, i_rst_n, r_out_valid, !(r_out_hi && r_out_lo) && (r_out_period >= ppc_pkg::COUNT_MIN), "clamp flags or period out of range")

    // The high clamp always comes with the full-scale period.
    `PPC_ASSERT_IMPLY(a_hi_period, i_clk, i_rst_n, r_out_valid && r_out_hi, r_out_period == ppc_pkg::COUNT_MAX, "high clamp without full-scale period")

    // An accepted item moves the sequencer straight into the prescaler search.
    `PPC_ASSERT_NEXT(a_accept_pick, i_clk, i_rst_n, w_in_xfer, r_state == S_PICK, "accepted item did not start the search")

    // The divider only finishes while the sequencer waits for it.
    `PPC_ASSERT_IMPLY(a_div_done_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV, "divider finished outside the divide phase")

endmodule

>>> tb/pwm_prescaler_and_period_calc_test.sv
// ----------------------------------------------------------------------------
// PWM prescaler and period calculator: testbench
// Drives frequency and duty requests through the block under several clock
// and count-width settings, with random input idling and output stalling.
// A scoreboard predicts the prescaler, top count, compare count and clamp
// flags of every request and checks each result transfer against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwm_prescaler_and_period_calc_test;

    // The prescaler table of the timer, as values and as powers of two.
    localparam int NUM_PRESCALERS = 5;
    localparam longint unsigned PRESCALE_RATIO [5] = '{1, 8, 64, 256, 1024};
    localparam int PRESCALE_LOG2 [5] = '{0, 3, 6, 8, 10};

    localparam logic [27:0] FREQ_MAX = 28'hFFF_FFFF;
    localparam int PHASE_ITEMS = 93;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;

    // One result of the block: everything the timer needs for one setting.
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] duty;
        logic [10:0] ratio;
        logic        clamped_high;
        logic        clamped_low;
    } t_pwm_setup;

    // Predicts the timer setting for each accepted request and checks the
    // results in order against those predictions.
    class t_pwm_setup_scoreboard;
        logic [4:0]  master_log2;
        logic [4:0]  count_log2;
        t_pwm_setup  expected_setups [$];
        int          errors;

        function new();
            master_log2 = ppc_pkg::MASTER_LOG2_RST;
            count_log2  = ppc_pkg::COUNT_LOG2_RST;
            errors      = 0;
        endfunction

        function t_pwm_setup compute_setup(logic [27:0] freq, logic [16:0] duty_frac);
            t_pwm_setup      r;
            longint unsigned fl;
            longint unsigned num;
            longint unsigned den;
            longint unsigned quot;
            longint unsigned prod;
            int              thr_exp;
            int              cnt_exp;
            int              sel;
            bit              step_up;
            fl = freq;
            // First prescaler whose value exceeds 2^(M-C)/f; f is in 1/16 Hz,
            // hence the extra factor of 16 on the left of the compare.
            thr_exp = int'(master_log2) - int'(count_log2) + 4;
            sel = 0;
            step_up = 1'b1;
            while (sel < NUM_PRESCALERS - 1 && step_up) begin
                if (thr_exp >= 0)
                    step_up = (64'd1 << thr_exp) >= PRESCALE_RATIO[sel] * fl;
                else
                    step_up = (fl == 0);
                if (step_up)
                    sel++;
            end
            r.ratio = 11'(PRESCALE_RATIO[sel]);
            r.clamped_high = 1'b0;
            r.clamped_low = 1'b0;
            if (fl == 0) begin
                r.period = 16'hFFFF;
                r.clamped_high = 1'b1;
            end else begin
                cnt_exp = int'(master_log2) + 4 - PRESCALE_LOG2[sel];
                if (cnt_exp >= 0) begin
                    num = 64'd1 << cnt_exp;
                    den = fl;
                end else begin
                    num = 1;
                    den = fl << (-cnt_exp);
                end
                quot = (2 * num + den) / (2 * den);
                if (quot > 65535) begin
                    r.period = 16'hFFFF;
                    r.clamped_high = 1'b1;
                end else if (quot < 2) begin
                    r.period = 16'd2;
                    r.clamped_low = 1'b1;
                end else begin
                    r.period = quot[15:0];
                end
            end
            prod = (longint'(r.period) * duty_frac + 32768) >> 16;
            if (prod > 65535)
                prod = 65535;
            if (prod < 1)
                prod = 1;
            r.duty = prod[15:0];
            return r;
        endfunction

        function void note_request(logic [27:0] freq, logic [16:0] duty_frac);
            expected_setups.push_back(compute_setup(freq, duty_frac));
        endfunction

        function void compare_field(string field, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_setup(t_pwm_setup got);
            t_pwm_setup want;
            if (expected_setups.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, actual %0d/%0d/%0d",
                         $time, got.period, got.duty, got.ratio);
                errors++;
                return;
            end
            want = expected_setups.pop_front();
            compare_field("period_count", want.period, got.period);
            compare_field("duty_count", want.duty, got.duty);
            compare_field("divide_ratio", want.ratio, got.ratio);
            compare_field("clamped_high", want.clamped_high, got.clamped_high);
            compare_field("clamped_low", want.clamped_low, got.clamped_low);
        endfunction

        function int pending();
            return expected_setups.size();
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_wr_en = 1'b0;
    logic [ppc_pkg::CFG_IDX_W-1:0]      i_cfg_index = ppc_pkg::REG_MASTER_LOG2;
    logic [ppc_pkg::CFG_W-1:0]          i_cfg_wdata = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic [ppc_pkg::FREQ_W-1:0]         i_frequency_q4 = '0;
    logic [ppc_pkg::DUTY_W-1:0]         i_duty_fraction = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [ppc_pkg::COUNT_W-1:0]        o_period_count;
    logic [ppc_pkg::COUNT_W-1:0]        o_duty_count;
    logic [ppc_pkg::RATIO_W-1:0]        o_divide_ratio;
    logic                               o_clamped_high;
    logic                               o_clamped_low;

    t_pwm_setup_scoreboard sb = new();

    // Sender pacing: a burst of back-to-back transfers, then a random gap.
    int burst_left = 0;
    bit no_gaps = 1'b0;
    // Set by the stimulus to make the receiver hold off for a long stretch.
    bit hold_off_request = 1'b0;

    pwm_prescaler_and_period_calc #(
        .NUM_PRESCALERS (NUM_PRESCALERS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_frequency_q4  (i_frequency_q4),
        .i_duty_fraction (i_duty_fraction),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_period_count  (o_period_count),
        .o_duty_count    (o_duty_count),
        .o_divide_ratio  (o_divide_ratio),
        .o_clamped_high  (o_clamped_high),
        .o_clamped_low   (o_clamped_low)
    );

    always #1 i_clk = ~i_clk;

    // Offers one request and waits for its transfer. All inputs change only
    // right after a rising edge, and o_in_stall is read at the edge before
    // the block's own updates land, so the handshake is seen as the block
    // sees it. The valid stays high across a burst and is only lowered when
    // a gap follows, so it never gets two assignments in one step.
    task automatic offer(input logic [27:0] freq, input logic [16:0] duty_frac);
        int gap;
        i_in_valid      <= 1'b1;
        i_frequency_q4  <= freq;
        i_duty_fraction <= duty_frac;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(freq, duty_frac);
        if (burst_left > 0 || no_gaps) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = $urandom_range(1, 90);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Ends a phase: stops offering and waits until every result is back.
    // The block works on one request at a time and every request yields a
    // result, so once the last one has transferred the block is idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Writes the master-clock register and then the count-width register. Only
    // called while the block is idle and the input valid is low.
    task automatic set_config(input logic [4:0] master, input logic [4:0] count);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ppc_pkg::REG_MASTER_LOG2;
        i_cfg_wdata <= master;
        @(posedge i_clk);
        sb.master_log2 = master;
        i_cfg_index <= ppc_pkg::REG_COUNT_LOG2;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        sb.count_log2 = count;
        i_cfg_wr_en <= 1'b0;
    endtask

    // Frequencies spread over all magnitudes, with zero, the maximum and
    // values right at the prescaler thresholds of the current setting.
    function automatic logic [27:0] random_frequency();
        longint unsigned f;
        int              thr;
        int              width;
        case ($urandom_range(0, 19))
            0: f = 0;
            1: f = FREQ_MAX;
            2, 3, 4, 5: begin
                thr = int'(sb.master_log2) - int'(sb.count_log2) + 4;
                f = (thr < 0) ? 0 : (64'd1 << thr) / PRESCALE_RATIO[$urandom_range(0, 4)];
                f = f + $urandom_range(0, 2);
                f = (f == 0) ? 0 : f - 1;
                if (f > FREQ_MAX)
                    f = FREQ_MAX;
            end
            default: begin
                width = $urandom_range(1, 28);
                f = $urandom & ((64'd1 << width) - 1);
            end
        endcase
        return f[27:0];
    endfunction

    function automatic logic [16:0] random_duty();
        logic [16:0] d;
        case ($urandom_range(0, 9))
            0: d = 17'd0;
            1: d = 17'd65536;
            2: d = 17'd32768;
            3, 4: d = 17'($urandom);
            default: d = 17'($urandom_range(0, 65536));
        endcase
        return d;
    endfunction

    // Receiver: checks every result transfer and drives its stall. The stall
    // pattern switches between modes at random intervals, from no stall at all
    // to heavy stalling. On request it holds off for a long stretch so that the
    // block fills up and has to stall its input.
    initial begin : receiver
        int         mode_left;
        int         stall_mode;
        int         hold_left;
        t_pwm_setup got;
        mode_left = 0;
        stall_mode = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = {o_period_count, o_duty_count, o_divide_ratio,
                       o_clamped_high, o_clamped_low};
                sb.check_setup(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(100, 600);
                end
                mode_left--;
                case (stall_mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Main stimulus: a directed set under the reset setting, then random
    // phases, each under its own clock and count-width setting.
    initial begin : stimulus
        logic [4:0] phase_master [10];
        logic [4:0] phase_count [10];
        phase_master = '{5'd16, 5'd28, 5'd16, 5'd28, 5'd23, 5'd0, 5'd31, 5'd20, 5'd0, 5'd0};
        phase_count  = '{5'd8, 5'd16, 5'd16, 5'd8, 5'd16, 5'd31, 5'd0, 5'd12, 5'd0, 5'd0};
        phase_master[8] = 5'($urandom_range(0, 31));
        phase_count[8]  = 5'($urandom_range(0, 31));
        phase_master[9] = 5'($urandom_range(16, 28));
        phase_count[9]  = 5'($urandom_range(8, 16));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: master 2^23 Hz, count width 16, so the prescaler
        // thresholds sit at f = 2048, 256, 32 and 8 (in 1/16 Hz).
        offer(28'd0, 17'd32768);          // zero frequency: slowest prescaler
        offer(28'd1, 17'd65536);          // slowest request, count clamps high
        offer(FREQ_MAX, 17'd0);           // fastest request, count clamps low
        offer(28'd16, 17'h1FFFF);         // duty above full scale saturates
        offer(28'd2047, 17'd1);
        offer(28'd2048, 17'd65535);
        offer(28'd2049, 17'd32767);
        offer(28'd255, 17'd16384);
        offer(28'd256, 17'd49152);
        offer(28'd257, 17'd65536);
        offer(28'd32, 17'd100);
        offer(28'd33, 17'd1000);
        offer(28'd8, 17'd20000);
        offer(28'd9, 17'd40000);
        offer(28'd2, 17'd60000);
        offer(28'd3, 17'd65536);
        offer(28'h800_0000, 17'd1);       // tiny duty still gives a count of one
        offer(28'd1_000_000, 17'd32768);
        offer(28'd12345, 17'h10001);
        offer(28'h555_5555, 17'h0AAAA);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            set_config(phase_master[ph], phase_count[ph]);
            if (ph == PRESSURE_PHASE) begin
                // Keep offering back to back while the receiver holds off.
                no_gaps = 1'b1;
                hold_off_request = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                offer(random_frequency(), random_duty());
                if (no_gaps && n == 20)
                    no_gaps = 1'b0;
            end
            drain();
        end

        // Let a few more cycles pass so a stray extra result would be seen.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
